/* design/lse_pkg.sv */
package lse_pkg;

    // Fixed framing constants
    localparam int HEADER_BYTES    = 54;
    localparam int MAGIC_MAX_BYTES = 8;
    localparam int EXT_MAX_BYTES   = 4;
    localparam int QUEUE_DEPTH     = 2;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 3;

    typedef logic [2:0] t_section;

    localparam t_section SEC_HEADER = 3'd0;
    localparam t_section SEC_MAGIC  = 3'd1;
    localparam t_section SEC_EXTLEN = 3'd2;
    localparam t_section SEC_EXT    = 3'd3;
    localparam t_section SEC_SIZE   = 3'd4;
    localparam t_section SEC_DATA   = 3'd5;
    localparam t_section SEC_TAIL   = 3'd6;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_MAGIC_CHARS    = 3'd0;
    localparam t_cfg_idx CFG_MAGIC_LEN      = 3'd1;
    localparam t_cfg_idx CFG_EXT_CHARS      = 3'd2;
    localparam t_cfg_idx CFG_EXT_LEN        = 3'd3;
    localparam t_cfg_idx CFG_SECRET_SIZE    = 3'd4;
    localparam t_cfg_idx CFG_COVER_CAPACITY = 3'd5;

    typedef struct packed {
        logic       mode;
        logic [7:0] value_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] stego_byte;
        t_section   section;
        logic       payload_wanted;
        logic       underrun;
        logic       capacity_short;
    } t_out_item;

    // Classified item as it sits in the queue
    typedef struct packed {
        logic       is_offer;
        logic [7:0] value;
    } t_cmd;

    typedef struct packed {
        logic [63:0] magic_chars;
        logic [3:0]  magic_len;
        logic [31:0] ext_chars;
        logic [2:0]  ext_len;
        logic [31:0] secret_size;
        logic [31:0] cover_capacity;
    } t_cfg;

endpackage

/* design/lsb_stego_embedder_unit.sv */
// Hides a framed payload in the least significant bits of a cover byte stream, one
// payload bit per cover byte, LSB first: header bytes pass through, then magic
// characters, the extension length, the extension characters, the secret size and
// the secret data, after which every byte passes through. Each cover item (mode 0)
// yields one result; a payload offer (mode 1) yields none and is held until a data
// byte needs it, and the payload_wanted flag on a result asks the feeder for the
// next one. Items are accepted every cycle while the queue has room: a two-entry
// queue separates input acceptance from the embedding engine, which retires one
// item per clock while the output is taken and holds its result in an output
// register. The user writes registers through the plain write port only while no
// item is in flight, which the block itself does not enforce; capacity is compared
// live against the framed total on every cover byte.
module lsb_stego_embedder_unit #(
    parameter int LENGTH_FIELD_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  lse_pkg::t_in_item                   i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output lse_pkg::t_out_item                  o_out_item,
    input  logic                                i_cfg_we,
    input  logic [lse_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [lse_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    lse_pkg::t_cfg r_cfg;
    logic          q_valid;
    lse_pkg::t_cmd q_cmd;
    logic          q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic_chars    <= '0;
            r_cfg.magic_len      <= 4'd2;
            r_cfg.ext_chars      <= '0;
            r_cfg.ext_len        <= '0;
            r_cfg.secret_size    <= '0;
            r_cfg.cover_capacity <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lse_pkg::CFG_MAGIC_CHARS:    r_cfg.magic_chars    <= i_cfg_data;
                lse_pkg::CFG_MAGIC_LEN:      r_cfg.magic_len      <= i_cfg_data[3:0];
                lse_pkg::CFG_EXT_CHARS:      r_cfg.ext_chars      <= i_cfg_data[31:0];
                lse_pkg::CFG_EXT_LEN:        r_cfg.ext_len        <= i_cfg_data[2:0];
                lse_pkg::CFG_SECRET_SIZE:    r_cfg.secret_size    <= i_cfg_data[31:0];
                lse_pkg::CFG_COVER_CAPACITY: r_cfg.cover_capacity <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    lse_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_q_valid  (q_valid),
        .o_q_cmd    (q_cmd),
        .i_q_pop    (q_pop)
    );

    lse_back #(
        .LENGTH_FIELD_BITS (LENGTH_FIELD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

/* design/lse_front.sv */
module lse_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  lse_pkg::t_in_item i_in_item,
    output logic              o_q_valid,
    output lse_pkg::t_cmd     o_q_cmd,
    input  logic              i_q_pop
);

    localparam int PTR_W = $clog2(lse_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(lse_pkg::QUEUE_DEPTH + 1);

    lse_pkg::t_cmd    r_mem [lse_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             push;
    lse_pkg::t_cmd    cmd;

    assign o_in_stall = (r_count == CNT_W'(lse_pkg::QUEUE_DEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != '0);
    assign o_q_cmd    = r_mem[r_rd_ptr];

    // Classify: a payload offer only touches the held byte
    always_comb begin
        cmd.is_offer = i_in_item.mode;
        cmd.value    = i_in_item.value_byte;
    end

    always_comb begin
        n_count = r_count;
        if (push && !i_q_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!push && i_q_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(lse_pkg::QUEUE_DEPTH - 1)) ? '0
                          : r_wr_ptr + PTR_W'(1);
            end
            if (i_q_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(lse_pkg::QUEUE_DEPTH - 1)) ? '0
                          : r_rd_ptr + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(lse_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> r_count != '0)
        else $error("pop from empty queue");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !i_q_pop) |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("queue count lost an item");

endmodule

/* design/lse_back.sv */
module lse_back #(
    parameter int LENGTH_FIELD_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lse_pkg::t_cfg      i_cfg,
    input  logic               i_q_valid,
    input  lse_pkg::t_cmd      i_q_cmd,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lse_pkg::t_out_item o_out_item
);

    localparam int BW  = $clog2(LENGTH_FIELD_BITS);
    localparam int TW  = 36;

    lse_pkg::t_section  r_sec;
    logic [BW-1:0]      r_bit;
    logic [31:0]        r_idx;
    logic [7:0]         r_held;
    logic               r_held_valid;
    logic               r_out_valid;
    lse_pkg::t_out_item r_out;

    lse_pkg::t_section  n_sec;
    logic [BW-1:0]      n_bit;
    logic [31:0]        n_idx;
    logic [7:0]         n_held;
    logic               n_held_valid;
    lse_pkg::t_out_item n_out;

    logic [3:0]         eff_magic;
    logic [2:0]         eff_ext;
    logic [6:0]         nonempty;
    logic [TW-1:0]      total;
    logic               cap_ok;
    lse_pkg::t_section  s0;
    lse_pkg::t_section  sec;
    logic [BW-1:0]      bit_c;
    logic [31:0]        idx_c;
    logic [BW:0]        bit_p1;
    logic [BW:0]        bpi;
    logic               emb_bit;
    logic [31:0]        ext_vec;

    function automatic logic [31:0] sec_len(input lse_pkg::t_section s,
                                            input logic [3:0] m,
                                            input logic [2:0] e,
                                            input logic [31:0] size);
        logic [31:0] len;
        case (s)
            lse_pkg::SEC_HEADER: len = 32'(lse_pkg::HEADER_BYTES);
            lse_pkg::SEC_MAGIC:  len = 32'(m);
            lse_pkg::SEC_EXTLEN: len = 32'd1;
            lse_pkg::SEC_EXT:    len = 32'(e);
            lse_pkg::SEC_SIZE:   len = 32'd1;
            lse_pkg::SEC_DATA:   len = size;
            default:             len = '1;
        endcase
        return len;
    endfunction

    // First section after s that holds anything; the tail catches the rest
    function automatic lse_pkg::t_section next_sec(input lse_pkg::t_section s,
                                                   input logic [6:0] ne);
        lse_pkg::t_section r;
        r = lse_pkg::SEC_TAIL;
        for (int k = 5; k >= 0; k--) begin
            if (3'(k) > s && ne[k]) begin
                r = 3'(k);
            end
        end
        return r;
    endfunction

    assign eff_magic = (i_cfg.magic_len > 4'(lse_pkg::MAGIC_MAX_BYTES))
                     ? 4'(lse_pkg::MAGIC_MAX_BYTES) : i_cfg.magic_len;
    assign eff_ext   = (i_cfg.ext_len > 3'(lse_pkg::EXT_MAX_BYTES))
                     ? 3'(lse_pkg::EXT_MAX_BYTES) : i_cfg.ext_len;
    assign ext_vec   = {29'd0, eff_ext};

    assign nonempty = {1'b1,
                       i_cfg.secret_size != '0,
                       1'b1,
                       eff_ext != '0,
                       1'b1,
                       eff_magic != '0,
                       lse_pkg::HEADER_BYTES != 0};

    assign total = TW'(lse_pkg::HEADER_BYTES) + (TW'(eff_magic) << 3)
                 + TW'(2 * LENGTH_FIELD_BITS) + (TW'(eff_ext) << 3)
                 + (TW'(i_cfg.secret_size) << 3);
    assign cap_ok = TW'(i_cfg.cover_capacity) > total;

    assign o_q_pop = i_q_valid && (i_q_cmd.is_offer || !r_out_valid || !i_out_stall);

    always_comb begin
        s0     = (r_sec > lse_pkg::SEC_TAIL) ? lse_pkg::SEC_TAIL : r_sec;
        sec    = s0;
        bit_c  = r_bit;
        idx_c  = r_idx;
        // Leave a section whose position lies past its current length
        if (s0 != lse_pkg::SEC_TAIL
                && r_idx >= sec_len(s0, eff_magic, eff_ext, i_cfg.secret_size)) begin
            sec   = next_sec(s0, nonempty);
            bit_c = '0;
            idx_c = '0;
        end

        case (sec)
            lse_pkg::SEC_EXTLEN,
            lse_pkg::SEC_SIZE:   bpi = (BW+1)'(LENGTH_FIELD_BITS);
            lse_pkg::SEC_HEADER,
            lse_pkg::SEC_TAIL:   bpi = (BW+1)'(1);
            default:             bpi = (BW+1)'(8);
        endcase
        bit_p1 = {1'b0, bit_c} + (BW+1)'(1);

        case (sec)
            lse_pkg::SEC_MAGIC:  emb_bit = i_cfg.magic_chars[{idx_c[2:0], bit_c[2:0]}];
            lse_pkg::SEC_EXTLEN: emb_bit = ext_vec[5'(bit_c)];
            lse_pkg::SEC_EXT:    emb_bit = i_cfg.ext_chars[{idx_c[1:0], bit_c[2:0]}];
            lse_pkg::SEC_SIZE:   emb_bit = i_cfg.secret_size[5'(bit_c)];
            lse_pkg::SEC_DATA:   emb_bit = r_held[bit_c[2:0]];
            default:             emb_bit = 1'b0;
        endcase

        n_sec        = sec;
        n_bit        = bit_c;
        n_idx        = idx_c;
        n_held       = r_held;
        n_held_valid = r_held_valid;

        n_out.stego_byte     = i_q_cmd.value;
        n_out.section        = sec;
        n_out.payload_wanted = 1'b0;
        n_out.underrun       = 1'b0;
        n_out.capacity_short = 1'b0;

        if (i_q_cmd.is_offer) begin
            // Ignore an offer while a byte is already held
            n_sec = r_sec;
            n_bit = r_bit;
            n_idx = r_idx;
            if (!r_held_valid) begin
                n_held       = i_q_cmd.value;
                n_held_valid = 1'b1;
            end
        end else if (!cap_ok) begin
            n_out.capacity_short = 1'b1;
        end else begin
            if (sec == lse_pkg::SEC_DATA && bit_c == '0 && !r_held_valid) begin
                n_out.underrun = 1'b1;
            end else begin
                if (sec != lse_pkg::SEC_HEADER && sec != lse_pkg::SEC_TAIL) begin
                    n_out.stego_byte = {i_q_cmd.value[7:1], emb_bit};
                end
                if (sec != lse_pkg::SEC_TAIL) begin
                    if (bit_p1 >= bpi) begin
                        n_bit = '0;
                        n_idx = idx_c + 32'd1;
                        if (sec == lse_pkg::SEC_DATA) begin
                            n_held_valid = 1'b0;
                        end
                        if (n_idx >= sec_len(sec, eff_magic, eff_ext, i_cfg.secret_size)) begin
                            n_sec = next_sec(sec, nonempty);
                            n_idx = '0;
                        end
                    end else begin
                        n_bit = bit_p1[BW-1:0];
                    end
                end
            end
            n_out.payload_wanted = (n_sec == lse_pkg::SEC_DATA) && (n_bit == '0)
                                 && !n_held_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_held <= n_held;
        end
        if (o_q_pop && !i_q_cmd.is_offer) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec        <= lse_pkg::SEC_HEADER;
            r_bit        <= '0;
            r_idx        <= '0;
            r_held_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_sec        <= n_sec;
                r_bit        <= n_bit;
                r_idx        <= n_idx;
                r_held_valid <= n_held_valid;
            end
            if (o_q_pop && !i_q_cmd.is_offer) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_underrun_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.underrun) |-> r_out.section == lse_pkg::SEC_DATA)
        else $error("underrun reported outside the data section");

    a_short_is_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.capacity_short)
            |-> (!r_out.underrun && !r_out.payload_wanted))
        else $error("short capacity item carries other flags");

    a_held_from_offer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_held_valid) |-> $past(o_q_pop && i_q_cmd.is_offer))
        else $error("payload byte held without an offer");

    a_out_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result changed");

endmodule
